@@ src/nfcr_pkg.sv @@
// Shared types and constants for the NFC frame receiver.
`timescale 1ns / 1ps

package nfcr_pkg;

    // Number of bytes after the first one that the start-code search may consume.
    localparam int unsigned SEARCH_WINDOW = 64;
    localparam int unsigned SCAN_W = $clog2(SEARCH_WINDOW + 1);

    localparam logic [7:0] TFI_HOST = 8'hD5;
    localparam logic [7:0] START_LO = 8'h00;
    localparam logic [7:0] START_HI = 8'hFF;

    localparam logic [7:0] MAX_PAYLOAD_RESET = 8'hFF;

    // Register indexes of the configuration port.
    localparam logic [0:0] REG_MAX_PAYLOAD = 1'b0;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_SCAN    = 4'd1,
        PH_LEN     = 4'd2,
        PH_INV     = 4'd3,
        PH_LCS     = 4'd4,
        PH_TFI     = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_DCS     = 4'd7
    } t_phase;

    typedef enum logic [3:0] {
        ST_OK      = 4'd0,
        ST_ACK     = 4'd1,
        ST_NACK    = 4'd2,
        ST_BADINV  = 4'd3,
        ST_NOSTART = 4'd4,
        ST_LCS     = 4'd5,
        ST_TOOLONG = 4'd6,
        ST_TFI     = 4'd7,
        ST_DCS     = 4'd8
    } t_status;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       payload_valid;
        logic       last;
        t_status    status;
        logic [7:0] frame_length;
    } t_result;

endpackage

@@ src/nfcr_cfg.sv @@
// Configuration register block with an APB-style port.
`timescale 1ns / 1ps

module nfcr_cfg (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [7:0]  o_max_payload
);

    logic [7:0] r_max_payload;
    logic       w_hit;

    assign w_hit = (paddr[2] == nfcr_pkg::REG_MAX_PAYLOAD) && (paddr[1:0] == 2'b00);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= nfcr_pkg::MAX_PAYLOAD_RESET;
        end else if (psel && penable && pwrite && w_hit) begin
            r_max_payload <= pwdata[7:0];
        end
    end

    assign prdata        = w_hit ? {24'd0, r_max_payload} : 32'd0;
    assign pready        = 1'b1;
    assign o_max_payload = r_max_payload;

endmodule

@@ src/nfcr_parser.sv @@
// Per-byte frame parser: state registers and the next-state and result logic.
`timescale 1ns / 1ps

module nfcr_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_rx_byte,
    input  logic                i_start_req,
    input  logic [7:0]          i_max_payload,
    output logic                o_res_valid,
    output nfcr_pkg::t_result   o_res
);

    nfcr_pkg::t_phase                  r_phase, n_phase;
    logic [7:0]                        r_prev, n_prev;
    logic [nfcr_pkg::SCAN_W-1:0]       r_scan, n_scan;
    logic [7:0]                        r_len, n_len;
    logic [7:0]                        r_left, n_left;
    logic [7:0]                        r_sum, n_sum;

    logic       w_window_done;
    logic [7:0] w_sum_b;
    logic [7:0] w_len_m1;

    assign w_window_done = (r_scan >= nfcr_pkg::SCAN_W'(nfcr_pkg::SEARCH_WINDOW));
    assign w_sum_b       = r_sum + i_rx_byte;
    assign w_len_m1      = r_len - 8'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= nfcr_pkg::PH_IDLE;
            r_prev  <= 8'd0;
            r_scan  <= '0;
            r_len   <= 8'd0;
            r_left  <= 8'd0;
            r_sum   <= 8'd0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_prev  <= n_prev;
            r_scan  <= n_scan;
            r_len   <= n_len;
            r_left  <= n_left;
            r_sum   <= n_sum;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_prev      = r_prev;
        n_scan      = r_scan;
        n_len       = r_len;
        n_left      = r_left;
        n_sum       = r_sum;
        o_res_valid = 1'b0;
        o_res       = '{out_byte: 8'd0, payload_valid: 1'b0, last: 1'b1,
                        status: nfcr_pkg::ST_OK, frame_length: 8'd0};

        if (i_start_req) begin
            // A start request restarts the search with this byte, whatever came before.
            n_phase = nfcr_pkg::PH_SCAN;
            n_prev  = i_rx_byte;
            n_scan  = '0;
            n_len   = 8'd0;
            n_left  = 8'd0;
            n_sum   = 8'd0;
        end else begin
            unique case (r_phase)
                nfcr_pkg::PH_SCAN: begin
                    if (i_rx_byte == nfcr_pkg::START_HI && r_prev == nfcr_pkg::START_LO
                        && !w_window_done) begin
                        n_phase = nfcr_pkg::PH_LEN;
                    end else if (w_window_done) begin
                        n_phase      = nfcr_pkg::PH_IDLE;
                        o_res_valid  = 1'b1;
                        o_res.status = nfcr_pkg::ST_NOSTART;
                    end else begin
                        n_prev = i_rx_byte;
                        n_scan = r_scan + nfcr_pkg::SCAN_W'(1);
                    end
                end
                nfcr_pkg::PH_LEN: begin
                    n_len   = i_rx_byte;
                    n_phase = (i_rx_byte == 8'h00 || i_rx_byte == 8'hFF) ?
                              nfcr_pkg::PH_INV : nfcr_pkg::PH_LCS;
                end
                nfcr_pkg::PH_INV: begin
                    n_phase     = nfcr_pkg::PH_IDLE;
                    o_res_valid = 1'b1;
                    if (i_rx_byte != ~r_len) begin
                        o_res.status = nfcr_pkg::ST_BADINV;
                    end else if (r_len == 8'h00) begin
                        o_res.status = nfcr_pkg::ST_ACK;
                    end else begin
                        o_res.status = nfcr_pkg::ST_NACK;
                    end
                end
                nfcr_pkg::PH_LCS: begin
                    n_left = w_len_m1;
                    if ((r_len + i_rx_byte) != 8'd0) begin
                        n_left       = r_left;
                        n_phase      = nfcr_pkg::PH_IDLE;
                        o_res_valid  = 1'b1;
                        o_res.status = nfcr_pkg::ST_LCS;
                    end else if (w_len_m1 > i_max_payload) begin
                        n_phase      = nfcr_pkg::PH_IDLE;
                        o_res_valid  = 1'b1;
                        o_res.status = nfcr_pkg::ST_TOOLONG;
                    end else begin
                        n_phase = nfcr_pkg::PH_TFI;
                    end
                end
                nfcr_pkg::PH_TFI: begin
                    if (i_rx_byte != nfcr_pkg::TFI_HOST) begin
                        n_phase      = nfcr_pkg::PH_IDLE;
                        o_res_valid  = 1'b1;
                        o_res.status = nfcr_pkg::ST_TFI;
                    end else begin
                        n_sum   = i_rx_byte;
                        n_phase = (r_left == 8'd0) ? nfcr_pkg::PH_DCS : nfcr_pkg::PH_PAYLOAD;
                    end
                end
                nfcr_pkg::PH_PAYLOAD: begin
                    n_sum       = w_sum_b;
                    n_left      = r_left - 8'd1;
                    if (r_left == 8'd1) begin
                        n_phase = nfcr_pkg::PH_DCS;
                    end
                    o_res_valid = 1'b1;
                    o_res       = '{out_byte: i_rx_byte, payload_valid: 1'b1, last: 1'b0,
                                    status: nfcr_pkg::ST_OK, frame_length: 8'd0};
                end
                nfcr_pkg::PH_DCS: begin
                    n_sum       = w_sum_b;
                    n_phase     = nfcr_pkg::PH_IDLE;
                    o_res_valid = 1'b1;
                    if (w_sum_b != 8'd0) begin
                        o_res.status = nfcr_pkg::ST_DCS;
                    end else begin
                        o_res.frame_length = w_len_m1;
                    end
                end
                default: begin
                    n_phase = nfcr_pkg::PH_IDLE;
                end
            endcase
        end
    end

endmodule

@@ src/nfcr_out_buf.sv @@
// Result register with a skid stage on the output stream.
`timescale 1ns / 1ps

module nfcr_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  nfcr_pkg::t_result i_res,
    output logic              o_ready,
    output logic              o_valid,
    output nfcr_pkg::t_result o_res,
    input  logic              i_take_ready
);

    logic              r_out_valid;
    nfcr_pkg::t_result r_out;
    logic              r_skid_valid;
    nfcr_pkg::t_result r_skid;
    logic              w_take;

    assign w_take = r_out_valid && i_take_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            priority if (r_skid_valid && w_take) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end else if (i_valid && (!r_out_valid || w_take)) begin
                r_out       <= i_res;
                r_out_valid <= 1'b1;
            end else if (i_valid) begin
                r_skid       <= i_res;
                r_skid_valid <= 1'b1;
            end else if (w_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

endmodule

@@ src/nfc_frame_receiver.sv @@
// Results are registered before the output stream; input stalls while the skid slot is full.
// Throughput: one byte request per cycle; the skid stage keeps that rate for one stalled result.
// The rate is set by the combinational parser update between the state and result registers.
// Reset (i_rst_n low, synchronous) returns the parser to idle, empties the result and skid
// stages and sets max_payload to 255.
`timescale 1ns / 1ps

module nfc_frame_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input byte stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic        s_axis_tuser,   // [0] start_req
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] out_byte, [11:8] status, [19:12] frame_length
    output logic        m_axis_tuser,   // [0] payload_valid
    output logic        m_axis_tlast,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic              w_accept;
    logic [7:0]        w_max_payload;
    logic              w_res_valid;
    nfcr_pkg::t_result w_res;
    nfcr_pkg::t_result w_out;

    // A byte request is taken whenever the skid stage is free.
    assign w_accept = s_axis_tvalid && s_axis_tready;

    nfcr_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_max_payload (w_max_payload)
    );

    // The parser advances its state on every accepted byte and reports at most
    // one result for it: a payload byte or the frame's final status.
    nfcr_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_rx_byte     (s_axis_tdata),
        .i_start_req   (s_axis_tuser),
        .i_max_payload (w_max_payload),
        .o_res_valid   (w_res_valid),
        .o_res         (w_res)
    );

    // Results are registered; a second slot absorbs one result while the
    // downstream side stalls, so input ready does not depend on output ready.
    nfcr_out_buf u_out_buf (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_accept && w_res_valid),
        .i_res        (w_res),
        .o_ready      (s_axis_tready),
        .o_valid      (m_axis_tvalid),
        .o_res        (w_out),
        .i_take_ready (m_axis_tready)
    );

    assign m_axis_tdata = {4'd0, w_out.frame_length, w_out.status, w_out.out_byte};
    assign m_axis_tuser = w_out.payload_valid;
    assign m_axis_tlast = w_out.last;

    // The skid slot only fills behind an occupied result register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !u_out_buf.r_skid_valid || u_out_buf.r_out_valid)
        else $error("skid slot full while result register empty");

    // A full skid slot stays full until the result register drains.
    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!s_axis_tready && !m_axis_tready) |=> !s_axis_tready)
        else $error("skid slot emptied without a drain");

    // A payload result is never the last of a frame and carries no status.
    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (!m_axis_tlast && m_axis_tdata[19:8] == 12'd0))
        else $error("payload result with status fields set");

    // A status result carries a zero data byte and the frame length only when ok.
    a_status_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |->
        (m_axis_tlast && m_axis_tdata[7:0] == 8'd0
         && (m_axis_tdata[11:8] == 4'd0 || m_axis_tdata[19:12] == 8'd0)))
        else $error("malformed status result");

endmodule
